@@ rtl/assert_macros.svh @@
// assertion helpers, clocked on clk; all but the _ALWAYS form are disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TLCA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TLCA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLCA_ASSERT(lbl, prop, msg)
`define TLCA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ rtl/tlca_pkg.sv @@
package tlca_pkg;

  localparam int MAX_NODES   = 1024;
  localparam int JUMP_LEVELS = 11;
  localparam int NODE_W      = 11;
  localparam int IDX_W       = $clog2(MAX_NODES);
  localparam int LVL_W       = $clog2(JUMP_LEVELS + 1);
  localparam int EDGE_CAP    = MAX_NODES - 1;
  localparam int EDGE_W      = $clog2(EDGE_CAP + 1);
  localparam int EDGE_AW     = (EDGE_CAP > 1) ? $clog2(EDGE_CAP) : 1;
  localparam int JUMP_DEPTH  = MAX_NODES * JUMP_LEVELS;
  localparam int JUMP_AW     = $clog2(JUMP_DEPTH);

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_BUILD = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  typedef struct packed {
    logic [1:0]        op;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } in_t;

  typedef struct packed {
    logic [NODE_W-1:0] ancestor;
    logic              error;
  } out_t;

  // table row is the level, column is the node
  function automatic logic [JUMP_AW-1:0] jump_addr(input logic [LVL_W-1:0] lvl,
                                                   input logic [NODE_W-1:0] node);
    int a;
    a = int'(lvl) * MAX_NODES + int'(node) - 1;
    return JUMP_AW'(a);
  endfunction

  function automatic logic [IDX_W-1:0] node_idx(input logic [NODE_W-1:0] node);
    logic [NODE_W-1:0] t;
    t = node - NODE_W'(1);
    return t[IDX_W-1:0];
  endfunction

endpackage

@@ rtl/tlca_ram.sv @@
module tlca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/tlca_ctrl.sv @@
`include "assert_macros.svh"

module tlca_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  tlca_pkg::in_t              in_data,
  output logic                       busy,
  input  logic                       cfg_we,
  input  logic [tlca_pkg::NODE_W-1:0] node_n,
  output logic                       out_valid,
  output tlca_pkg::out_t             out_data
);

  localparam int NW = tlca_pkg::NODE_W;
  localparam int IW = tlca_pkg::IDX_W;
  localparam int LW = tlca_pkg::LVL_W;
  localparam int EW = tlca_pkg::EDGE_W;
  localparam int SW = tlca_pkg::IDX_W + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_ROOT, S_EDGE, S_EDGE2, S_EDGE3, S_POP1, S_POP2,
    S_DBL_A, S_DBL_B, S_DBL_C, S_Q1, S_Q2, S_LIFT, S_LIFT2, S_CMP,
    S_UP_A, S_UP_B, S_UP_C, S_FIN, S_FIN2
  } state_t;

  state_t          state_r, state_nxt;
  logic [NW-1:0]   i_r, i_nxt;
  logic [LW-1:0]   k_r, k_nxt;
  logic [SW-1:0]   sp_r, sp_nxt;
  logic [NW-1:0]   cur_r, cur_nxt;
  logic [IW-1:0]   dep_r, dep_nxt;
  logic [EW-1:0]   e_r, e_nxt;
  logic [EW-1:0]   etot_r, etot_nxt;
  logic            built_r, built_nxt;
  logic [NW-1:0]   u_r, u_nxt, v_r, v_nxt, nx_r, nx_nxt, pu_r, pu_nxt;
  logic [IW-1:0]   da_r, da_nxt, diff_r, diff_nxt;
  logic            ov_r, ov_nxt;
  tlca_pkg::out_t  od_r, od_nxt;

  // memory ports
  logic                          e_we;
  logic [tlca_pkg::EDGE_AW-1:0]  e_wa, e_ra;
  logic [2*NW-1:0]               e_wd, e_rd;
  logic                          j_we;
  logic [tlca_pkg::JUMP_AW-1:0]  j_wa, j_ra;
  logic [NW-1:0]                 j_wd, j_rd;
  logic                          d_we;
  logic [IW-1:0]                 d_wa, d_ra;
  logic [IW:0]                   d_wd, d_rd;
  logic                          s_we;
  logic [IW-1:0]                 s_wa, s_ra, s_wd, s_rd;
  logic                          r_we;
  logic [IW-1:0]                 r_wa, r_ra;
  logic [EW-1:0]                 r_wd, r_rd;

  logic [NW-1:0] ex, ey, nsel;
  logic          nhit;

  tlca_ram #(.WIDTH(2*NW), .DEPTH(tlca_pkg::EDGE_CAP)) u_edge (
    .clk, .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));
  tlca_ram #(.WIDTH(NW), .DEPTH(tlca_pkg::JUMP_DEPTH)) u_jump (
    .clk, .we(j_we), .waddr(j_wa), .wdata(j_wd), .raddr(j_ra), .rdata(j_rd));
  tlca_ram #(.WIDTH(IW+1), .DEPTH(tlca_pkg::MAX_NODES)) u_depth (
    .clk, .we(d_we), .waddr(d_wa), .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));
  tlca_ram #(.WIDTH(IW), .DEPTH(tlca_pkg::MAX_NODES)) u_stack (
    .clk, .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  tlca_ram #(.WIDTH(EW), .DEPTH(tlca_pkg::MAX_NODES)) u_resume (
    .clk, .we(r_we), .waddr(r_wa), .wdata(r_wd), .raddr(r_ra), .rdata(r_rd));

  assign busy      = (state_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  assign ex = e_rd[2*NW-1:NW];
  assign ey = e_rd[NW-1:0];

  // neighbor of the current node across the edge just read
  always_comb begin
    nsel = '0;
    nhit = 1'b0;
    if (ex == cur_r) begin
      nsel = ey;
      nhit = 1'b1;
    end else if (ey == cur_r) begin
      nsel = ex;
      nhit = 1'b1;
    end
    if (nsel == '0 || nsel > node_n) begin
      nhit = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    k_nxt     = k_r;
    sp_nxt    = sp_r;
    cur_nxt   = cur_r;
    dep_nxt   = dep_r;
    e_nxt     = e_r;
    etot_nxt  = etot_r;
    built_nxt = built_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    nx_nxt    = nx_r;
    pu_nxt    = pu_r;
    da_nxt    = da_r;
    diff_nxt  = diff_r;
    ov_nxt    = 1'b0;
    od_nxt    = od_r;
    e_we = 1'b0; e_wa = '0; e_wd = '0; e_ra = '0;
    j_we = 1'b0; j_wa = '0; j_wd = '0; j_ra = '0;
    d_we = 1'b0; d_wa = '0; d_wd = '0; d_ra = '0;
    s_we = 1'b0; s_wa = '0; s_wd = '0; s_ra = '0;
    r_we = 1'b0; r_wa = '0; r_wd = '0; r_ra = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_data.op)
            tlca_pkg::OP_LOAD: begin
              if (etot_r < EW'(tlca_pkg::EDGE_CAP)) begin
                e_we     = 1'b1;
                e_wa     = etot_r[tlca_pkg::EDGE_AW-1:0];
                e_wd     = {in_data.node_a, in_data.node_b};
                etot_nxt = etot_r + EW'(1);
              end
              built_nxt = 1'b0;
            end
            tlca_pkg::OP_BUILD: begin
              i_nxt     = NW'(1);
              state_nxt = S_INIT;
            end
            tlca_pkg::OP_QUERY: begin
              u_nxt = in_data.node_a;
              v_nxt = in_data.node_b;
              if (!built_r || in_data.node_a == '0 || in_data.node_a > node_n ||
                  in_data.node_b == '0 || in_data.node_b > node_n) begin
                ov_nxt = 1'b1;
                od_nxt = '{ancestor: '0, error: 1'b1};
              end else begin
                d_ra      = tlca_pkg::node_idx(in_data.node_a);
                state_nxt = S_Q1;
              end
            end
            default: ;
          endcase
        end
        if (cfg_we) begin
          built_nxt = 1'b0;
        end
      end

      S_INIT: begin
        d_we = 1'b1; d_wa = tlca_pkg::node_idx(i_r); d_wd = '0;
        r_we = 1'b1; r_wa = tlca_pkg::node_idx(i_r); r_wd = '0;
        j_we = 1'b1; j_wa = tlca_pkg::jump_addr('0, i_r); j_wd = '0;
        i_nxt = i_r + NW'(1);
        if (i_r == node_n) begin
          state_nxt = S_ROOT;
        end
      end

      S_ROOT: begin
        d_we = 1'b1; d_wa = '0; d_wd = {1'b1, IW'(0)};
        s_we = 1'b1; s_wa = '0; s_wd = '0;
        sp_nxt    = SW'(1);
        cur_nxt   = NW'(1);
        dep_nxt   = '0;
        e_nxt     = '0;
        state_nxt = S_EDGE;
      end

      S_EDGE: begin
        if (e_r == etot_r) begin
          sp_nxt = sp_r - SW'(1);
          if (sp_r == SW'(1)) begin
            k_nxt     = '0;
            i_nxt     = NW'(1);
            state_nxt = S_DBL_A;
          end else begin
            s_ra      = IW'(sp_r - SW'(2));
            state_nxt = S_POP1;
          end
        end else begin
          e_ra      = e_r[tlca_pkg::EDGE_AW-1:0];
          state_nxt = S_EDGE2;
        end
      end

      S_EDGE2: begin
        if (nhit) begin
          nx_nxt    = nsel;
          d_ra      = tlca_pkg::node_idx(nsel);
          state_nxt = S_EDGE3;
        end else begin
          e_nxt     = e_r + EW'(1);
          state_nxt = S_EDGE;
        end
      end

      S_EDGE3: begin
        if (d_rd[IW]) begin
          e_nxt = e_r + EW'(1);
        end else begin
          d_we = 1'b1; d_wa = tlca_pkg::node_idx(nx_r); d_wd = {1'b1, dep_r + IW'(1)};
          j_we = 1'b1; j_wa = tlca_pkg::jump_addr('0, nx_r); j_wd = cur_r;
          r_we = 1'b1; r_wa = tlca_pkg::node_idx(cur_r); r_wd = e_r + EW'(1);
          if (sp_r < SW'(tlca_pkg::MAX_NODES)) begin
            s_we   = 1'b1;
            s_wa   = sp_r[IW-1:0];
            s_wd   = tlca_pkg::node_idx(nx_r);
            sp_nxt = sp_r + SW'(1);
          end
          cur_nxt = nx_r;
          dep_nxt = dep_r + IW'(1);
          e_nxt   = '0;
        end
        state_nxt = S_EDGE;
      end

      S_POP1: begin
        cur_nxt   = NW'(s_rd) + NW'(1);
        d_ra      = s_rd;
        r_ra      = s_rd;
        state_nxt = S_POP2;
      end

      S_POP2: begin
        e_nxt     = r_rd;
        dep_nxt   = d_rd[IW-1:0];
        state_nxt = S_EDGE;
      end

      S_DBL_A: begin
        j_ra      = tlca_pkg::jump_addr(k_r, i_r);
        state_nxt = S_DBL_B;
      end

      S_DBL_B, S_DBL_C: begin
        if (state_r == S_DBL_B && j_rd != '0) begin
          j_ra      = tlca_pkg::jump_addr(k_r, j_rd);
          state_nxt = S_DBL_C;
        end else begin
          j_we = 1'b1;
          j_wa = tlca_pkg::jump_addr(k_r + LW'(1), i_r);
          j_wd = (state_r == S_DBL_B) ? '0 : j_rd;
          state_nxt = S_DBL_A;
          if (i_r == node_n) begin
            i_nxt = NW'(1);
            k_nxt = k_r + LW'(1);
            if (k_r == LW'(tlca_pkg::JUMP_LEVELS - 2)) begin
              built_nxt = 1'b1;
              state_nxt = S_IDLE;
            end
          end else begin
            i_nxt = i_r + NW'(1);
          end
        end
      end

      S_Q1: begin
        if (!d_rd[IW]) begin
          ov_nxt    = 1'b1;
          od_nxt    = '{ancestor: '0, error: 1'b1};
          state_nxt = S_IDLE;
        end else begin
          da_nxt    = d_rd[IW-1:0];
          d_ra      = tlca_pkg::node_idx(v_r);
          state_nxt = S_Q2;
        end
      end

      S_Q2: begin
        if (!d_rd[IW]) begin
          ov_nxt    = 1'b1;
          od_nxt    = '{ancestor: '0, error: 1'b1};
          state_nxt = S_IDLE;
        end else begin
          if (da_r < d_rd[IW-1:0]) begin
            u_nxt    = v_r;
            v_nxt    = u_r;
            diff_nxt = d_rd[IW-1:0] - da_r;
          end else begin
            diff_nxt = da_r - d_rd[IW-1:0];
          end
          k_nxt     = '0;
          state_nxt = S_LIFT;
        end
      end

      S_LIFT: begin
        if (diff_r == '0) begin
          state_nxt = S_CMP;
        end else if (k_r == LW'(tlca_pkg::JUMP_LEVELS)) begin
          ov_nxt    = 1'b1;
          od_nxt    = '{ancestor: '0, error: 1'b1};
          state_nxt = S_IDLE;
        end else if (diff_r[0]) begin
          j_ra      = tlca_pkg::jump_addr(k_r, u_r);
          state_nxt = S_LIFT2;
        end else begin
          diff_nxt = diff_r >> 1;
          k_nxt    = k_r + LW'(1);
        end
      end

      S_LIFT2: begin
        u_nxt    = j_rd;
        diff_nxt = diff_r >> 1;
        k_nxt    = k_r + LW'(1);
        if (j_rd == '0) begin
          ov_nxt    = 1'b1;
          od_nxt    = '{ancestor: '0, error: 1'b1};
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_LIFT;
        end
      end

      S_CMP: begin
        if (u_r == v_r) begin
          ov_nxt    = 1'b1;
          od_nxt    = '{ancestor: u_r, error: 1'b0};
          state_nxt = S_IDLE;
        end else begin
          k_nxt     = LW'(tlca_pkg::JUMP_LEVELS - 1);
          state_nxt = S_UP_A;
        end
      end

      S_UP_A: begin
        j_ra      = tlca_pkg::jump_addr(k_r, u_r);
        state_nxt = S_UP_B;
      end

      S_UP_B: begin
        pu_nxt    = j_rd;
        j_ra      = tlca_pkg::jump_addr(k_r, v_r);
        state_nxt = S_UP_C;
      end

      S_UP_C: begin
        if (pu_r != j_rd) begin
          u_nxt = pu_r;
          v_nxt = j_rd;
        end
        if (k_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          k_nxt     = k_r - LW'(1);
          state_nxt = S_UP_A;
        end
      end

      S_FIN: begin
        j_ra      = tlca_pkg::jump_addr('0, u_r);
        state_nxt = S_FIN2;
      end

      S_FIN2: begin
        ov_nxt    = 1'b1;
        od_nxt    = '{ancestor: j_rd, error: (j_rd == '0)};
        state_nxt = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      etot_r  <= '0;
      built_r <= 1'b0;
      sp_r    <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      etot_r  <= etot_nxt;
      built_r <= built_nxt;
      sp_r    <= sp_nxt;
      ov_r    <= ov_nxt;
    end
    i_r    <= i_nxt;
    k_r    <= k_nxt;
    cur_r  <= cur_nxt;
    dep_r  <= dep_nxt;
    e_r    <= e_nxt;
    u_r    <= u_nxt;
    v_r    <= v_nxt;
    nx_r   <= nx_nxt;
    pu_r   <= pu_nxt;
    da_r   <= da_nxt;
    diff_r <= diff_nxt;
    od_r   <= od_nxt;
  end

  `TLCA_ASSERT(a_err_zero, ov_r && od_r.error |-> od_r.ancestor == '0, "error result carries a node")
  `TLCA_ASSERT(a_sp_bound, sp_r <= SW'(tlca_pkg::MAX_NODES), "walk stack overflow")
  `TLCA_ASSERT(a_built_src, $rose(built_r) |-> $past(state_r) == S_DBL_B || $past(state_r) == S_DBL_C, "tables marked built outside the doubling pass")
  `TLCA_ASSERT(a_build_go, start && !busy && in_data.op == tlca_pkg::OP_BUILD |=> state_r == S_INIT, "build transaction not started")
  `TLCA_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> state_r == S_IDLE && !ov_r, "not idle after reset")

endmodule

@@ rtl/tree_lca_binary_lifting_top.sv @@
// query: depth lookups, one lift step per bit of the depth gap with a table read per set bit,
// then a climb over the jump levels from the top; an invalid query answers without going busy
// build: an init pass over the n nodes, the root, then a walk that scans the edges and pops
// the stack, then a doubling pass for each of the 10 levels; a load is taken without going busy
// one transaction at a time; the jump table ram's single read port sets the query time
// synchronous active-low reset: node_count back to 1, no edges, tables not built
module tree_lca_binary_lifting_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  tlca_pkg::in_t               in_data,
  output logic                        out_valid,
  output tlca_pkg::out_t              out_data,
  input  logic                        cfg_we,
  input  logic [tlca_pkg::NODE_W-1:0] cfg_data
);

  localparam int NW = tlca_pkg::NODE_W;

  logic [NW-1:0] cfg_count_r;
  logic [NW-1:0] live_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= NW'(1);
    end else if (cfg_we) begin
      cfg_count_r <= cfg_data;
    end
  end

  // clamp to 1..MAX_NODES
  always_comb begin
    if (cfg_count_r == '0) begin
      live_n = NW'(1);
    end else if (cfg_count_r > NW'(tlca_pkg::MAX_NODES)) begin
      live_n = NW'(tlca_pkg::MAX_NODES);
    end else begin
      live_n = cfg_count_r;
    end
  end

  tlca_ctrl u_ctrl (
    .clk,
    .rst_n,
    .start,
    .in_data,
    .busy,
    .cfg_we,
    .node_n(live_n),
    .out_valid,
    .out_data
  );

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int NW          = tlca_pkg::NODE_W;
  localparam int MAX_NODES   = tlca_pkg::MAX_NODES;
  localparam int JUMP_LEVELS = tlca_pkg::JUMP_LEVELS;
  localparam int EDGE_CAP    = tlca_pkg::EDGE_CAP;

  typedef enum logic [1:0] {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef struct {
    row_kind_t      kind;
    tlca_pkg::in_t  item;
    bit             typed;
    tlca_pkg::out_t want;
    int             cfg_value;
  } row_t;

  localparam logic [1:0] OP_SPARE = 2'd3;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  tlca_pkg::in_t  in_data;
  logic out_valid;
  tlca_pkg::out_t out_data;
  logic cfg_we;
  logic [NW-1:0] cfg_data;

  tree_lca_binary_lifting_top DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // shadow of the block's state
  int unsigned node_count_reg;
  int          edge_src [0:EDGE_CAP-1];
  int          edge_dst [0:EDGE_CAP-1];
  int          edge_total;
  int          ancestor_at [0:MAX_NODES][0:JUMP_LEVELS-1];
  int          depth_of [0:MAX_NODES];
  bit          reached [0:MAX_NODES];
  int          dfs_stack [0:MAX_NODES-1];
  int          resume_edge [0:MAX_NODES];
  bit          tables_ready;

  tlca_pkg::out_t pending_answers[$];
  row_t directed_rows[$];
  int   mismatches, answers_seen, error_answers, loads_sent, builds_sent, queries_sent;
  bit   quiet;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d answers still pending", pending_answers.size());
    $display("Regression FAIL");
    $finish;
  end

  function automatic int live_nodes();
    if (node_count_reg < 1) return 1;
    if (node_count_reg > MAX_NODES) return MAX_NODES;
    return int'(node_count_reg);
  endfunction

  function automatic void rebuild_tables();
    int n = live_nodes();
    int sp, cur, e, nxt;
    bit pushed;
    for (int i = 1; i <= n; i++) begin
      reached[i] = 1'b0;
      depth_of[i] = 0;
      resume_edge[i] = 0;
      for (int k = 0; k < JUMP_LEVELS; k++) ancestor_at[i][k] = 0;
    end
    reached[1] = 1'b1;
    dfs_stack[0] = 1;
    sp = 1;
    while (sp > 0) begin
      cur = dfs_stack[sp-1];
      pushed = 1'b0;
      for (e = resume_edge[cur]; e < edge_total && !pushed; e++) begin
        if (edge_src[e] == cur) nxt = edge_dst[e];
        else if (edge_dst[e] == cur) nxt = edge_src[e];
        else nxt = -1;
        if (nxt >= 1 && nxt <= n && !reached[nxt]) begin
          reached[nxt] = 1'b1;
          depth_of[nxt] = depth_of[cur] + 1;
          ancestor_at[nxt][0] = cur;
          resume_edge[cur] = e + 1;
          if (sp < MAX_NODES) begin
            dfs_stack[sp] = nxt;
            sp++;
          end
          pushed = 1'b1;
        end
      end
      if (!pushed) sp--;
    end
    for (int k = 0; k + 1 < JUMP_LEVELS; k++)
      for (int i = 1; i <= n; i++)
        if (ancestor_at[i][k] != 0) ancestor_at[i][k+1] = ancestor_at[ancestor_at[i][k]][k];
    tables_ready = 1'b1;
  endfunction

  function automatic int common_ancestor(int u, int v);
    int n = live_nodes();
    int diff, t;
    if (!tables_ready || u < 1 || u > n || v < 1 || v > n) return 0;
    if (!reached[u] || !reached[v]) return 0;
    if (depth_of[u] < depth_of[v]) begin
      t = u; u = v; v = t;
    end
    diff = depth_of[u] - depth_of[v];
    for (int j = 0; j < JUMP_LEVELS && diff != 0; j++) begin
      if (diff & 1) u = ancestor_at[u][j];
      if (u == 0) return 0;
      diff >>= 1;
    end
    if (diff != 0) return 0;
    if (u != v) begin
      for (int k = JUMP_LEVELS - 1; k >= 0; k--)
        if (ancestor_at[u][k] != ancestor_at[v][k]) begin
          u = ancestor_at[u][k];
          v = ancestor_at[v][k];
        end
      u = ancestor_at[u][0];
    end
    return u;
  endfunction

  // advances the shadow state, returns 1 when the transaction yields an answer
  function automatic bit apply_transaction(tlca_pkg::in_t it, output tlca_pkg::out_t answer);
    int r;
    answer = '0;
    case (it.op)
      tlca_pkg::OP_LOAD: begin
        if (edge_total < EDGE_CAP) begin
          edge_src[edge_total] = it.node_a;
          edge_dst[edge_total] = it.node_b;
          edge_total++;
        end
        tables_ready = 1'b0;
        return 1'b0;
      end
      tlca_pkg::OP_BUILD: begin
        rebuild_tables();
        return 1'b0;
      end
      tlca_pkg::OP_QUERY: begin
        r = common_ancestor(it.node_a, it.node_b);
        answer.ancestor = NW'(r);
        answer.error = (r == 0);
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(negedge clk) begin
    tlca_pkg::out_t want;
    if (rst_n && out_valid) begin
      answers_seen++;
      if (out_data.error) error_answers++;
      if (pending_answers.size() == 0) begin
        report_mismatch("answer with nothing pending, ancestor", out_data.ancestor, 0);
      end else begin
        want = pending_answers.pop_front();
        if (out_data.ancestor !== want.ancestor)
          report_mismatch("ancestor", out_data.ancestor, want.ancestor);
        if (out_data.error !== want.error)
          report_mismatch("error flag", out_data.error, want.error);
      end
    end
  end

  // called at a rising edge; returns at the edge that accepts the transaction
  task automatic send_item(tlca_pkg::in_t it, bit typed = 1'b0,
                           tlca_pkg::out_t typed_want = '0);
    bit taken;
    tlca_pkg::out_t answer;
    bit has_answer;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    has_answer = apply_transaction(it, answer);
    if (has_answer) pending_answers = {pending_answers, (typed ? typed_want : answer)};
    case (it.op)
      tlca_pkg::OP_LOAD:  loads_sent++;
      tlca_pkg::OP_BUILD: builds_sent++;
      tlca_pkg::OP_QUERY: queries_sent++;
      default: ;
    endcase
  endtask

  task automatic drain();
    bit idle;
    start <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    do begin
      @(negedge clk);
      idle = !busy;
      @(posedge clk);
    end while (!idle);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_node_count(int value);
    drain();
    cfg_we <= 1'b1;
    cfg_data <= NW'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    node_count_reg = value & 11'h7FF;
    tables_ready = 1'b0;
  endtask

  function automatic tlca_pkg::in_t make_item(logic [1:0] op, int a, int b);
    tlca_pkg::in_t it;
    it.op = op;
    it.node_a = NW'(a);
    it.node_b = NW'(b);
    return it;
  endfunction

  function automatic void add_row(logic [1:0] op, int a, int b, bit typed = 1'b0,
                                  int anc = 0, bit err = 1'b0);
    row_t r;
    r.kind = ROW_ITEM;
    r.item = make_item(op, a, b);
    r.typed = typed;
    r.want.ancestor = NW'(anc);
    r.want.error = err;
    r.cfg_value = 0;
    directed_rows = {directed_rows, r};
  endfunction

  function automatic void add_cfg_row(int value);
    row_t r;
    r.kind = ROW_CFG;
    r.item = '0;
    r.typed = 1'b0;
    r.want = '0;
    r.cfg_value = value;
    directed_rows = {directed_rows, r};
  endfunction

  function automatic int pick_node(int n, int span);
    case ($urandom_range(0, 15))
      0: return 0;
      1: return n + $urandom_range(1, 3);
      2: return 2047;
      3: return $urandom_range(1, n);
      default: return $urandom_range(1, span);
    endcase
  endfunction

  // load a random tree over nodes 1..span, some as chains, with a few bad edges
  task automatic load_tree(int span);
    int label [];
    int t, j, p, n;
    bit chain;
    n = live_nodes();
    chain = ($urandom_range(0, 2) == 0);
    label = new[span + 1];
    for (int i = 1; i <= span; i++) label[i] = i;
    for (int i = span; i > 2; i--) begin
      j = $urandom_range(2, i);
      t = label[i]; label[i] = label[j]; label[j] = t;
    end
    for (int i = 2; i <= span; i++) begin
      p = chain ? i - 1 : $urandom_range(1, i - 1);
      case ($urandom_range(0, 11))
        0: send_item(make_item(tlca_pkg::OP_LOAD, label[i], label[i]));
        1: send_item(make_item(tlca_pkg::OP_LOAD, label[i], pick_node(n, span) | 11'h400));
        2: send_item(make_item(tlca_pkg::OP_LOAD, 0, label[i]));
        3: send_item(make_item(tlca_pkg::OP_LOAD, $urandom_range(1, span),
                               $urandom_range(1, span)));
        default: ;
      endcase
      if ($urandom_range(0, 1)) send_item(make_item(tlca_pkg::OP_LOAD, label[p], label[i]));
      else send_item(make_item(tlca_pkg::OP_LOAD, label[i], label[p]));
    end
  endtask

  task automatic run_phase(int cfg_value, int tree_nodes, int query_count);
    int n, span;
    write_node_count(cfg_value);
    n = live_nodes();
    span = (tree_nodes < n) ? tree_nodes : n;
    if (span > 1) load_tree(span);
    // stale tables must answer with error
    send_item(make_item(tlca_pkg::OP_QUERY, $urandom_range(1, n), $urandom_range(1, n)));
    send_item(make_item(tlca_pkg::OP_BUILD, $urandom, $urandom));
    for (int q = 0; q < query_count; q++) begin
      if ($urandom_range(0, 29) == 0)
        send_item(make_item(OP_SPARE, $urandom, $urandom));
      send_item(make_item(tlca_pkg::OP_QUERY, pick_node(n, span), pick_node(n, span)));
    end
  endtask

  initial begin
    int spans [0:13];
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    quiet = 1'b0;
    mismatches = 0;
    answers_seen = 0;
    error_answers = 0;
    loads_sent = 0;
    builds_sent = 0;
    queries_sent = 0;
    node_count_reg = 1;
    edge_total = 0;
    tables_ready = 1'b0;
    for (int i = 0; i <= MAX_NODES; i++) begin
      reached[i] = 1'b0;
      depth_of[i] = 0;
      resume_edge[i] = 0;
      for (int k = 0; k < JUMP_LEVELS; k++) ancestor_at[i][k] = 0;
    end

    // directed part: reset state first, then a small known tree
    add_row(tlca_pkg::OP_QUERY, 1, 1, 1'b1, 0, 1'b1);
    add_row(tlca_pkg::OP_BUILD, 0, 0);
    add_row(tlca_pkg::OP_QUERY, 1, 1, 1'b1, 1, 1'b0);
    add_row(tlca_pkg::OP_QUERY, 0, 1, 1'b1, 0, 1'b1);
    add_row(tlca_pkg::OP_QUERY, 1, 2, 1'b1, 0, 1'b1);
    add_row(tlca_pkg::OP_QUERY, 2047, 2047, 1'b1, 0, 1'b1);
    add_row(OP_SPARE, 2047, 2047);
    add_row(tlca_pkg::OP_LOAD, 1, 2);
    add_row(tlca_pkg::OP_QUERY, 1, 1, 1'b1, 0, 1'b1);
    add_row(tlca_pkg::OP_LOAD, 3, 3);
    add_row(tlca_pkg::OP_LOAD, 2047, 1);
    add_row(tlca_pkg::OP_BUILD, 2047, 2047);
    add_row(tlca_pkg::OP_QUERY, 1, 1, 1'b1, 1, 1'b0);
    add_cfg_row(6);
    add_row(tlca_pkg::OP_LOAD, 3, 2);
    add_row(tlca_pkg::OP_LOAD, 2, 4);
    add_row(tlca_pkg::OP_LOAD, 5, 3);
    add_row(tlca_pkg::OP_LOAD, 4, 6);
    add_row(tlca_pkg::OP_LOAD, 6, 1);
    add_row(tlca_pkg::OP_BUILD, 0, 0);
    add_row(tlca_pkg::OP_QUERY, 5, 6);
    add_row(tlca_pkg::OP_QUERY, 6, 5);
    add_row(tlca_pkg::OP_QUERY, 4, 4);
    add_row(tlca_pkg::OP_QUERY, 3, 2);
    add_row(tlca_pkg::OP_QUERY, 1, 7, 1'b1, 0, 1'b1);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) write_node_count(directed_rows[i].cfg_value);
      else send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    end

    // pause until every answer is back before random traffic
    drain();

    for (int p = 0; p < 14; p++) begin
      case (p)
        3:       run_phase(1024, 20, 25);
        5:       run_phase(0, 1, 10);
        7:       run_phase(2047, 16, 25);
        9:       run_phase(1, 1, 10);
        default: begin
          spans[p] = $urandom_range(2, 24);
          run_phase(spans[p], spans[p], 45);
        end
      endcase
    end

    run_phase($urandom_range(2, 10), 10, 30);
    quiet = 1'b1;
    run_phase(10, 10, 60);

    drain();
    $display("%0d loads (%0d edges kept), %0d builds, %0d queries over node counts 0 to 2047",
             loads_sent, edge_total, builds_sent, queries_sent);
    $display("%0d answers checked, %0d of them errors", answers_seen, error_answers);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ tree_lca_binary_lifting_top.f @@
+incdir+rtl
rtl/tlca_pkg.sv
rtl/tlca_ram.sv
rtl/tlca_ctrl.sv
rtl/tree_lca_binary_lifting_top.sv
sim/testbench.sv
